// File: hw/rtl/ti_tagged_record_parser_macros.svh
// Assertion macros for the tagged record parser.
// The assertions are clocked by clk and disabled while arst_n is low.
`ifndef TI_TAGGED_RECORD_PARSER_MACROS_SVH
`define TI_TAGGED_RECORD_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define TRP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ti_tagged_record_parser: assertion failed");
`define TRP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ti_tagged_record_parser: assertion failed");
`else
`define TRP_ASSERT_NOW(label, ante, cons)
`define TRP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/trp_pkg.sv
package trp_pkg;

	localparam logic [7:0] MAX_DESC = 8'd250;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_8     = 8'h38;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_K     = 8'h4B;

	localparam logic [15:0] HDR_SKIP_LEN = 16'd8;
	localparam logic [15:0] DESC_OVERHEAD = 16'd5;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_DESC = 2'd1,
		KIND_ERR  = 2'd2,
		KIND_END  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_TAG   = 3'd0,
		ERR_HEX   = 3'd1,
		ERR_SUM   = 3'd2,
		ERR_EOL   = 3'd3,
		ERR_DESC  = 3'd4,
		ERR_TRUNC = 3'd5
	} err_t;

	typedef enum logic [12:0] {
		PH_TAG     = 13'b0000000000001,
		PH_STAR    = 13'b0000000000010,
		PH_B1      = 13'b0000000000100,
		PH_B2      = 13'b0000000001000,
		PH_HDR     = 13'b0000000010000,
		PH_HDRSKIP = 13'b0000000100000,
		PH_CHK     = 13'b0000001000000,
		PH_IGN     = 13'b0000010000000,
		PH_ADDR    = 13'b0000100000000,
		PH_EOL     = 13'b0001000000000,
		PH_DLEN    = 13'b0010000000000,
		PH_DESC    = 13'b0100000000000,
		PH_SWALLOW = 13'b1000000000000
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] addr;
		logic [7:0]  value;
		logic        last;
		err_t        code;
	} res_t;

	// Bit 4 set means the character is not a hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd16;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			v = {1'b0, c[3:0] + 4'd9};
		end
		return v;
	endfunction

	function automatic res_t err_res(input err_t code);
		res_t r;
		r = '0;
		r.kind = KIND_ERR;
		r.code = code;
		return r;
	endfunction

endpackage

// File: hw/rtl/trp_core.sv
module trp_core #(
	parameter logic [7:0] MAX_DESC = trp_pkg::MAX_DESC
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [7:0]    ch,
	input  logic          at_end,
	output logic          res_valid,
	output trp_pkg::res_t res,
	output logic          halted
);

	trp_pkg::phase_t phase_q, phase_d;
	logic [15:0] addr_q, addr_d;
	logic [15:0] sum_q, sum_d;
	logic [15:0] exp_q, exp_d;
	logic [15:0] acc_q, acc_d;
	logic [2:0]  dc_q, dc_d;
	logic [15:0] cr_q, cr_d;
	logic [7:0]  de_q, de_d;
	logic        halted_q, halted_d;

	logic [15:0] sum_nxt;
	logic [4:0]  hv;
	logic [15:0] acc_nxt;
	logic [2:0]  dc_nxt;
	logic [15:0] cr_dec;
	logic [7:0]  de_inc;
	logic        hex_done;

	assign sum_nxt = (ch == trp_pkg::CH_NL) ? 16'd0 : sum_q + {8'd0, ch};
	assign hv      = trp_pkg::hex_value(ch);
	assign acc_nxt = {acc_q[11:0], hv[3:0]};
	assign dc_nxt  = dc_q + 3'd1;
	assign cr_dec  = (cr_q != 16'd0) ? cr_q - 16'd1 : cr_q;
	assign de_inc  = de_q + 8'd1;
	assign hex_done = (phase_q == trp_pkg::PH_STAR || phase_q == trp_pkg::PH_B1 ||
		phase_q == trp_pkg::PH_B2) ? (dc_nxt >= 3'd2) : (dc_nxt >= 3'd4);

	always_comb begin
		phase_d   = phase_q;
		addr_d    = addr_q;
		sum_d     = sum_q;
		exp_d     = exp_q;
		acc_d     = acc_q;
		dc_d      = dc_q;
		cr_d      = cr_q;
		de_d      = de_q;
		halted_d  = halted_q;
		res_valid = 1'b0;
		res       = '0;
		if (!halted_q) begin
			if (at_end) begin
				sum_d     = 16'd0;
				halted_d  = 1'b1;
				res_valid = 1'b1;
				unique case (phase_q) inside
					trp_pkg::PH_EOL: begin
						res = trp_pkg::err_res(trp_pkg::ERR_EOL);
					end
					trp_pkg::PH_DESC: begin
						res = trp_pkg::err_res(trp_pkg::ERR_DESC);
					end
					trp_pkg::PH_STAR, trp_pkg::PH_B1, trp_pkg::PH_B2, trp_pkg::PH_HDR,
					trp_pkg::PH_CHK, trp_pkg::PH_IGN, trp_pkg::PH_ADDR,
					trp_pkg::PH_DLEN: begin
						res = trp_pkg::err_res(trp_pkg::ERR_TRUNC);
					end
					default: begin
						res.kind = trp_pkg::KIND_END;
					end
				endcase
			end else begin
				sum_d = sum_nxt;
				unique case (phase_q) inside
					trp_pkg::PH_SWALLOW: begin
					end
					trp_pkg::PH_HDRSKIP: begin
						cr_d = cr_dec;
						if (cr_dec == 16'd0) begin
							phase_d = trp_pkg::PH_TAG;
						end
					end
					trp_pkg::PH_EOL: begin
						if (ch != trp_pkg::CH_NL) begin
							halted_d  = 1'b1;
							res_valid = 1'b1;
							res       = trp_pkg::err_res(trp_pkg::ERR_EOL);
						end else begin
							phase_d = trp_pkg::PH_TAG;
						end
					end
					trp_pkg::PH_DESC: begin
						if (ch == trp_pkg::CH_NL) begin
							halted_d  = 1'b1;
							res_valid = 1'b1;
							res       = trp_pkg::err_res(trp_pkg::ERR_DESC);
						end else begin
							cr_d = cr_dec;
							if (cr_dec == 16'd0) begin
								phase_d = trp_pkg::PH_TAG;
							end
							if (de_q < MAX_DESC) begin
								de_d       = de_inc;
								res_valid  = 1'b1;
								res.kind   = trp_pkg::KIND_DESC;
								res.value  = ch;
								res.last   = (cr_dec == 16'd0) || (de_inc == MAX_DESC);
							end
						end
					end
					trp_pkg::PH_STAR, trp_pkg::PH_B1, trp_pkg::PH_B2, trp_pkg::PH_HDR,
					trp_pkg::PH_CHK, trp_pkg::PH_IGN, trp_pkg::PH_ADDR,
					trp_pkg::PH_DLEN: begin
						if (hv[4]) begin
							halted_d  = 1'b1;
							res_valid = 1'b1;
							res       = trp_pkg::err_res(trp_pkg::ERR_HEX);
						end else begin
							acc_d = acc_nxt;
							dc_d  = dc_nxt;
							if (hex_done) begin
								unique case (phase_q) inside
									trp_pkg::PH_STAR, trp_pkg::PH_B1, trp_pkg::PH_B2: begin
										addr_d    = addr_q + 16'd1;
										res_valid = 1'b1;
										res.kind  = trp_pkg::KIND_DATA;
										res.addr  = addr_q;
										res.value = acc_nxt[7:0];
										if (phase_q == trp_pkg::PH_B1) begin
											phase_d = trp_pkg::PH_B2;
											acc_d   = 16'd0;
											dc_d    = 3'd0;
										end else begin
											phase_d  = trp_pkg::PH_TAG;
											res.last = 1'b1;
										end
									end
									trp_pkg::PH_HDR: begin
										phase_d = trp_pkg::PH_HDRSKIP;
										cr_d    = trp_pkg::HDR_SKIP_LEN;
									end
									trp_pkg::PH_CHK: begin
										phase_d = trp_pkg::PH_TAG;
										if (acc_nxt != exp_q) begin
											halted_d  = 1'b1;
											res_valid = 1'b1;
											res       = trp_pkg::err_res(trp_pkg::ERR_SUM);
										end
									end
									trp_pkg::PH_ADDR: begin
										addr_d  = acc_nxt;
										phase_d = trp_pkg::PH_TAG;
									end
									trp_pkg::PH_DLEN: begin
										if (acc_nxt < trp_pkg::DESC_OVERHEAD) begin
											halted_d  = 1'b1;
											res_valid = 1'b1;
											res       = trp_pkg::err_res(trp_pkg::ERR_DESC);
										end else begin
											cr_d    = acc_nxt - trp_pkg::DESC_OVERHEAD;
											de_d    = 8'd0;
											phase_d = (acc_nxt == trp_pkg::DESC_OVERHEAD) ?
												trp_pkg::PH_TAG : trp_pkg::PH_DESC;
										end
									end
									default: begin
										phase_d = trp_pkg::PH_TAG;
									end
								endcase
							end
						end
					end
					default: begin
						phase_d = trp_pkg::PH_TAG;
						unique case (ch)
							trp_pkg::CH_STAR: begin
								phase_d = trp_pkg::PH_STAR;
								acc_d   = 16'd0;
								dc_d    = 3'd0;
							end
							trp_pkg::CH_B: begin
								phase_d = trp_pkg::PH_B1;
								acc_d   = 16'd0;
								dc_d    = 3'd0;
							end
							trp_pkg::CH_0: begin
								phase_d = trp_pkg::PH_HDR;
								acc_d   = 16'd0;
								dc_d    = 3'd0;
							end
							trp_pkg::CH_7: begin
								exp_d   = 16'd0 - sum_nxt;
								phase_d = trp_pkg::PH_CHK;
								acc_d   = 16'd0;
								dc_d    = 3'd0;
							end
							trp_pkg::CH_8: begin
								phase_d = trp_pkg::PH_IGN;
								acc_d   = 16'd0;
								dc_d    = 3'd0;
							end
							trp_pkg::CH_9: begin
								phase_d = trp_pkg::PH_ADDR;
								acc_d   = 16'd0;
								dc_d    = 3'd0;
							end
							trp_pkg::CH_K: begin
								phase_d = trp_pkg::PH_DLEN;
								acc_d   = 16'd0;
								dc_d    = 3'd0;
							end
							trp_pkg::CH_F: begin
								phase_d = trp_pkg::PH_EOL;
							end
							trp_pkg::CH_COLON: begin
								phase_d = trp_pkg::PH_SWALLOW;
							end
							default: begin
								halted_d  = 1'b1;
								res_valid = 1'b1;
								res       = trp_pkg::err_res(trp_pkg::ERR_TAG);
							end
						endcase
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= trp_pkg::PH_TAG;
			addr_q   <= '0;
			sum_q    <= '0;
			exp_q    <= '0;
			acc_q    <= '0;
			dc_q     <= '0;
			cr_q     <= '0;
			de_q     <= '0;
			halted_q <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_d;
			addr_q   <= addr_d;
			sum_q    <= sum_d;
			exp_q    <= exp_d;
			acc_q    <= acc_d;
			dc_q     <= dc_d;
			cr_q     <= cr_d;
			de_q     <= de_d;
			halted_q <= halted_d;
		end
	end

	assign halted = halted_q;

endmodule

// File: hw/rtl/trp_out_reg.sv
module trp_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  trp_pkg::res_t res,
	input  logic          out_stall,
	output logic          out_valid,
	output trp_pkg::res_t res_q
);

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;

endmodule

// File: hw/rtl/ti_tagged_record_parser.sv
// Tagged load-file parser taking one character per request and sustaining one request
// per clock while the input is not stalled. A request is captured in an input register,
// then parsed by a state update that writes at most one result into the output
// register, so a result passes through the input register and the output register
// before it is presented. The input stalls only while a request that yields a
// result waits for a stalled output register; requests that yield no result keep
// flowing.
`include "ti_tagged_record_parser_macros.svh"

module ti_tagged_record_parser #(
	parameter logic [7:0] MAX_DESC = trp_pkg::MAX_DESC
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ch,
	input  logic        at_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [15:0] target_address,
	output logic [7:0]  byte_value,
	output logic        last_of_record,
	output logic [2:0]  error_code
);

	logic          valid_s1;
	logic [7:0]    ch_s1;
	logic          at_end_s1;
	logic          fire;
	logic          load;
	logic          res_valid;
	logic          halted;
	trp_pkg::res_t res;
	trp_pkg::res_t res_q;

	assign fire     = valid_s1 && (!res_valid || !(out_valid && out_stall));
	assign load     = fire && res_valid;
	assign in_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1     <= ch;
			at_end_s1 <= at_end;
		end
	end

	trp_core #(
		.MAX_DESC(MAX_DESC)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.ch       (ch_s1),
		.at_end   (at_end_s1),
		.res_valid(res_valid),
		.res      (res),
		.halted   (halted)
	);

	trp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.res      (res),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.res_q    (res_q)
	);

	assign kind           = res_q.kind;
	assign target_address = res_q.addr;
	assign byte_value     = res_q.value;
	assign last_of_record = res_q.last;
	assign error_code     = res_q.code;

	`TRP_ASSERT_NEXT(a_halt_sticky, halted, halted)
	`TRP_ASSERT_NEXT(a_error_halts, load && (res.kind == trp_pkg::KIND_ERR), halted)
	`TRP_ASSERT_NOW(a_quiet_when_halted, halted, !res_valid)
	`TRP_ASSERT_NEXT(a_request_held, valid_s1 && res_valid && out_valid && out_stall, valid_s1)

endmodule
